FILE: hdl/rfc_pkg.sv
// Shared types and constants for the response frame checker.
// No dependencies; used by every rfc_* module and the top level.
`default_nettype none

package rfc_pkg;

  // Width of the word_count register.
  localparam int unsigned WC_W = 10;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] ACK_RESET   = 8'hFC;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FRAME_MODE = 2'd0,
    REG_EXP_ACK    = 2'd1,
    REG_EXP_ADDR   = 2'd2,
    REG_WORD_COUNT = 2'd3
  } reg_idx_t;

  // End-of-frame status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HEADER   = 3'd1,
    ST_ACK      = 3'd2,
    ST_ADDRESS  = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_t;

  typedef struct packed {
    logic            frame_mode;
    logic [7:0]      expected_ack;
    logic [15:0]     expected_address;
    logic [WC_W-1:0] word_count;
  } cfg_t;

  typedef struct packed {
    logic        is_status;
    logic [15:0] data_word;
    status_t     status;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/rfc_cfg_regs.sv
// Configuration register file for the response frame checker.
// Depends on rfc_pkg (cfg_t, reg_idx_t, reset values).
`default_nettype none

module rfc_cfg_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  output rfc_pkg::cfg_t            cfg
);

  rfc_pkg::cfg_t regs;
  rfc_pkg::cfg_t regs_next;

  always_comb begin
    regs_next = regs;
    if (cfg_valid) begin
      unique case (rfc_pkg::reg_idx_t'(cfg_index))
        rfc_pkg::REG_FRAME_MODE: regs_next.frame_mode       = cfg_data[0];
        rfc_pkg::REG_EXP_ACK:    regs_next.expected_ack     = cfg_data[7:0];
        rfc_pkg::REG_EXP_ADDR:   regs_next.expected_address = cfg_data;
        rfc_pkg::REG_WORD_COUNT: regs_next.word_count       = cfg_data[rfc_pkg::WC_W-1:0];
        default:                 regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_mode       <= 1'b0;
      regs.expected_ack     <= rfc_pkg::ACK_RESET;
      regs.expected_address <= 16'd0;
      regs.word_count       <= '0;
    end else begin
      regs <= regs_next;
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

FILE: hdl/rfc_frame_ctl.sv
// Input byte register and per-byte frame checks (position, checksum, first error).
// Depends on rfc_pkg (cfg_t, result_t, status_t, HEADER_BYTE).
`default_nettype none

module rfc_frame_ctl #(
  parameter int unsigned MAX_WORDS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  rfc_pkg::cfg_t    cfg,
  input  wire logic        buf_full,
  output logic             push,
  output rfc_pkg::result_t result
);

  localparam int unsigned POS_W = $clog2(6 + 2 * MAX_WORDS + 1);

  logic             in_q_valid;
  logic [7:0]       in_q_byte;
  logic             proc;

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       running_sum;
  logic [7:0]       running_sum_next;
  logic [7:0]       low_byte_hold;
  logic [7:0]       low_byte_hold_next;
  rfc_pkg::status_t first_error;
  rfc_pkg::status_t first_error_next;

  logic [POS_W-1:0] words;
  logic [POS_W-1:0] csum_pos;
  logic [7:0]       sum_add;

  // Input register; holds while the result buffer is full.
  assign in_stall = in_q_valid && buf_full;
  assign proc     = in_q_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte <= rx_byte;
    end
  end

  // Checksum position from the configuration; word_count clamps to MAX_WORDS.
  always_comb begin
    if (int'(cfg.word_count) > int'(MAX_WORDS)) begin
      words = POS_W'(MAX_WORDS);
    end else begin
      words = POS_W'(cfg.word_count);
    end
    if (cfg.frame_mode) begin
      csum_pos = POS_W'(6) + (words << 1);
    end else begin
      csum_pos = POS_W'(6);
    end
  end

  assign sum_add = running_sum + in_q_byte;

  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    low_byte_hold_next = low_byte_hold;
    first_error_next   = first_error;
    push               = 1'b0;
    result             = '0;

    if (proc) begin
      if (byte_position >= csum_pos) begin
        // checksum byte: report and rearm for the next header
        push             = 1'b1;
        result.is_status = 1'b1;
        result.last      = 1'b1;
        result.status    = first_error;
        if (first_error == rfc_pkg::ST_OK && in_q_byte != running_sum) begin
          result.status = rfc_pkg::ST_CHECKSUM;
        end
        byte_position_next = '0;
        running_sum_next   = 8'd0;
        low_byte_hold_next = 8'd0;
        first_error_next   = rfc_pkg::ST_OK;
      end else begin
        byte_position_next = byte_position + POS_W'(1);
        if (byte_position == '0) begin
          if (first_error == rfc_pkg::ST_OK && in_q_byte != rfc_pkg::HEADER_BYTE) begin
            first_error_next = rfc_pkg::ST_HEADER;
          end
        end else begin
          running_sum_next = sum_add;
          if (byte_position == POS_W'(1)) begin
            if (first_error == rfc_pkg::ST_OK && in_q_byte != cfg.expected_ack) begin
              first_error_next = rfc_pkg::ST_ACK;
            end
          end else if (byte_position == POS_W'(2)) begin
            low_byte_hold_next = in_q_byte;
          end else if (byte_position == POS_W'(3)) begin
            if (first_error == rfc_pkg::ST_OK &&
                {in_q_byte, low_byte_hold} != cfg.expected_address) begin
              first_error_next = rfc_pkg::ST_ADDRESS;
            end
          end else if (!cfg.frame_mode || byte_position >= POS_W'(6)) begin
            // data word bytes; size field in multi mode is only summed
            if (!byte_position[0]) begin
              low_byte_hold_next = in_q_byte;
            end else begin
              push             = 1'b1;
              result.data_word = {in_q_byte, low_byte_hold};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= 8'd0;
      low_byte_hold <= 8'd0;
      first_error   <= rfc_pkg::ST_OK;
    end else begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      low_byte_hold <= low_byte_hold_next;
      first_error   <= first_error_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rfc_result_buf.sv
// Two-entry result buffer between the checker and the output channel.
// Depends on rfc_pkg (result_t).
`default_nettype none

module rfc_result_buf (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  rfc_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  wire logic         out_stall,
  output rfc_pkg::result_t  head
);

  rfc_pkg::result_t ent [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic [1:0]       cnt_next;
  logic             pop;

  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = ent[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/response_frame_checker.sv
// Response frame checker. Takes one received byte per beat and checks a
// response frame: header 0xFF, acknowledge byte, 16-bit address, then one data
// word (single mode) or a 16-bit size plus word_count data words (multi mode),
// and an 8-bit additive checksum over all bytes after the header; 16-bit
// fields arrive low byte first. Each data word comes out as a beat when its
// high byte arrives (is_status=0). The checksum byte produces a status beat
// (is_status=1, last=1) carrying ok or the first error seen in byte order;
// drop the frame's words if it is not ok. The size field is summed but never
// checked, and a word_count above MAX_WORDS acts as MAX_WORDS. Rate: one byte
// per clock while the result buffer has room. A byte is registered on accept,
// checked from the input register once the result buffer has room, and its
// result is written to that buffer and shown from there. A two-entry result
// buffer lets input continue while one result waits; input stalls only when
// both entries are held. Configuration writes are always taken (cfg_ready is
// tied high) and must only be made while the block is idle.
// Depends on rfc_pkg, rfc_cfg_regs, rfc_frame_ctl, rfc_result_buf.
`default_nettype none

module response_frame_checker #(
  parameter int unsigned MAX_WORDS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_status,
  output logic [15:0]      data_word,
  output logic [2:0]       status,
  output logic             last,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  rfc_pkg::cfg_t    cfg;
  rfc_pkg::result_t ctl_result;
  rfc_pkg::result_t head;
  logic             push;
  logic             buf_full;

  assign cfg_ready = 1'b1;

  rfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Per-byte checks; state advances only when the buffer has room.
  rfc_frame_ctl #(
    .MAX_WORDS (MAX_WORDS)
  ) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .buf_full (buf_full),
    .push     (push),
    .result   (ctl_result)
  );

  rfc_result_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (ctl_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign is_status = head.is_status;
  assign data_word = head.data_word;
  assign status    = 3'(head.status);
  assign last      = head.last;

endmodule

`default_nettype wire
